// File: sv/hws_pkg.sv
package hws_pkg;

    // Parameter defaults
    localparam int WHEEL_SIZE_DEF = 8;
    localparam int MAX_TASKS_DEF  = 32;

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int TASK_ID_W = 5;
    localparam int DELAY_W   = 32;
    localparam int TICK_W    = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_DELAY  = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    // Controller to datapath
    typedef struct packed {
        logic load;       // input beat taken: latch task, form deadline
        logic tick_adv;   // advance counter and current spoke
        logic remove;     // drop the input task from the wheel
        logic mod_step;   // one step of the deadline-to-spoke reduction
        logic dly_write;  // store deadline and spoke, mark waiting
        logic scan;       // collect candidates of the current spoke
        logic pick;       // take lowest candidate, read its deadline
        logic retire;     // candidate matched: retire it, hold for output
        logic emit;       // move held task to the output register
        logic emit_last;  // ...marked as last of the tick
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic task_ok;    // input task index below MAX_TASKS
        logic mod_done;
        logic pend_any;
        logic hit;
        logic have;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/hashed_timing_wheel_scheduler_unit.sv
// Hashed timing wheel for task delays.
// Input channel (i_s_axis_*): one beat per command. tuser carries the command
// (tick, delay, remove); tdata carries task_id and delay_ticks.
// A delay stores deadline = counter + delay_ticks (mod 2^32) and files the task
// under spoke deadline mod WHEEL_SIZE, replacing any earlier entry for it.
// A remove drops a waiting task; an idle or out-of-range task is ignored.
// A tick advances the counter, walks the tasks of the new current spoke in
// ascending index and releases those whose deadline equals the counter.
// Output channel (o_m_axis_*): one beat per released task, tlast on the last
// one of the tick; a tick with nothing due gives no beat.
// Remove and unused codes finish in the cycle they are taken. A delay reduces
// its deadline to a spoke by a mask with a power-of-two wheel, else byte-wise
// (residue of the 32-bit deadline). A tick scans its spoke; each candidate, a
// waiting task filed there, needs one deadline-store read and one compare.
// The last result sits in an output register, so the next command is taken
// while it waits. A stalled receiver holds the walk at the next release.
// Reset (synchronous, active low) clears the counter and all waiting flags;
// the deadline store needs no clearing.
module hashed_timing_wheel_scheduler_unit #(
    parameter int WHEEL_SIZE = hws_pkg::WHEEL_SIZE_DEF,
    parameter int MAX_TASKS  = hws_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [4:0] task_id, [36:5] delay_ticks, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [4:0] released_task, rest zero
    output logic        o_m_axis_tlast    // last_release
);
    import hws_pkg::*;

    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    logic [TASK_ID_W-1:0] w_released_task;

    hws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_cmd_code (i_s_axis_tuser),
        .o_ready    (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    hws_datapath #(
        .WHEEL_SIZE (WHEEL_SIZE),
        .MAX_TASKS  (MAX_TASKS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_task_id       (i_s_axis_tdata[TASK_ID_W-1:0]),
        .i_delay_ticks   (i_s_axis_tdata[TASK_ID_W +: DELAY_W]),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_released_task (w_released_task),
        .o_last_release  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {3'b000, w_released_task};

endmodule

// File: sv/hws_datapath.sv
module hws_datapath #(
    parameter int WHEEL_SIZE = hws_pkg::WHEEL_SIZE_DEF,
    parameter int MAX_TASKS  = hws_pkg::MAX_TASKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hws_pkg::t_dp_cmd               i_cmd,
    output hws_pkg::t_dp_sts               o_sts,
    input  logic [hws_pkg::TASK_ID_W-1:0]  i_task_id,
    input  logic [hws_pkg::DELAY_W-1:0]    i_delay_ticks,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [hws_pkg::TASK_ID_W-1:0]  o_released_task,
    output logic                           o_last_release
);
    import hws_pkg::*;

    localparam int SPOKE_W    = $clog2(WHEEL_SIZE);
    localparam int TASK_W     = $clog2(MAX_TASKS);
    localparam bit SPOKE_POW2 = ((WHEEL_SIZE & (WHEEL_SIZE - 1)) == 0);

    logic [TICK_W-1:0]    r_tick;
    logic [SPOKE_W-1:0]   r_cur_spoke;
    logic [DELAY_W-1:0]   r_deadline;
    logic [TASK_W-1:0]    r_task_idx;
    logic [SPOKE_W-1:0]   r_task_spoke [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_waiting;
    logic [MAX_TASKS-1:0] r_pend;
    logic [DELAY_W-1:0]   r_dl_mem [MAX_TASKS];
    logic [DELAY_W-1:0]   r_rd_data;
    logic [TASK_W-1:0]    r_rd_idx;
    logic [TASK_W-1:0]    r_hold;
    logic                 r_have;
    logic                 r_out_valid;
    logic [TASK_ID_W-1:0] r_out_task;
    logic                 r_out_last;

    logic [TASK_W-1:0]    w_in_idx;
    logic [DELAY_W-1:0]   w_sum;
    logic [MAX_TASKS-1:0] w_match;
    logic [TASK_W-1:0]    w_pick_idx;
    logic [SPOKE_W-1:0]   w_dl_spoke;
    logic                 w_mod_done;
    logic                 w_out_free;

    // (b * mul) mod WHEEL_SIZE for every byte value b, 8 bits per entry
    function automatic logic [2047:0] f_res_tab(input int mul);
        logic [2047:0] tab;
        tab = '0;
        for (int b = 0; b < 256; b++) begin
            tab[8*b +: 8] = 8'((b * mul) % WHEEL_SIZE);
        end
        return tab;
    endfunction

    assign w_in_idx   = TASK_W'(i_task_id);
    assign w_sum      = r_tick + i_delay_ticks;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            w_match[i] = r_waiting[i] && (r_task_spoke[i] == r_cur_spoke);
        end
    end

    // lowest pending candidate first
    always_comb begin
        w_pick_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_pick_idx = TASK_W'(i);
            end
        end
    end

    // deadline modulo wheel size
    generate
        if (SPOKE_POW2) begin : g_mask
            assign w_dl_spoke = r_deadline[SPOKE_W-1:0];
            assign w_mod_done = 1'b1;
        end else begin : g_serial
            // byte-wise residue, top byte first: r = (r*256 + byte) mod WHEEL_SIZE
            localparam int MOD_STEPS = DELAY_W / 8;
            localparam int CNT_W     = $clog2(MOD_STEPS + 1);
            localparam logic [2047:0] BYTE_RES  = f_res_tab(1);
            localparam logic [2047:0] SHIFT_RES = f_res_tab(256 % WHEEL_SIZE);
            logic [SPOKE_W-1:0] r_rem;
            logic [DELAY_W-1:0] r_mod_sh;
            logic [CNT_W-1:0]   r_mod_cnt;
            logic [SPOKE_W-1:0] w_shift_res;
            logic [SPOKE_W-1:0] w_byte_res;
            logic [SPOKE_W:0]   w_trial;
            logic [SPOKE_W:0]   w_red;

            assign w_shift_res = SHIFT_RES[{r_rem, 3'b000} +: SPOKE_W];
            assign w_byte_res  = BYTE_RES[{r_mod_sh[DELAY_W-1 -: 8], 3'b000} +: SPOKE_W];
            assign w_trial     = {1'b0, w_shift_res} + {1'b0, w_byte_res};
            assign w_red   = (w_trial >= (SPOKE_W+1)'(WHEEL_SIZE))
                           ? w_trial - (SPOKE_W+1)'(WHEEL_SIZE) : w_trial;
            assign w_dl_spoke = r_rem;
            assign w_mod_done = (r_mod_cnt == CNT_W'(MOD_STEPS));

            always_ff @(posedge i_clk) begin
                if (i_cmd.load) begin
                    r_rem     <= '0;
                    r_mod_sh  <= w_sum;
                    r_mod_cnt <= '0;
                end else if (i_cmd.mod_step && !w_mod_done) begin
                    r_rem     <= w_red[SPOKE_W-1:0];
                    r_mod_sh  <= {r_mod_sh[DELAY_W-9:0], 8'h00};
                    r_mod_cnt <= r_mod_cnt + 1'b1;
                end
            end
        end
    endgenerate

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_cur_spoke <= '0;
            r_waiting   <= '0;
            r_pend      <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tick_adv) begin
                r_tick      <= r_tick + 1'b1;
                r_cur_spoke <= (r_cur_spoke == SPOKE_W'(WHEEL_SIZE - 1))
                             ? '0 : r_cur_spoke + 1'b1;
            end
            if (i_cmd.remove) begin
                r_waiting[w_in_idx] <= 1'b0;
            end
            if (i_cmd.dly_write) begin
                r_waiting[r_task_idx] <= 1'b1;
            end
            if (i_cmd.retire) begin
                r_waiting[r_rd_idx] <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_pend <= w_match;
            end else if (i_cmd.pick) begin
                r_pend[w_pick_idx] <= 1'b0;
            end
            if (i_cmd.scan || (i_cmd.emit && i_cmd.emit_last)) begin
                r_have <= 1'b0;
            end else if (i_cmd.retire) begin
                r_have <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_deadline <= w_sum;
            r_task_idx <= w_in_idx;
        end
        if (i_cmd.dly_write) begin
            r_task_spoke[r_task_idx] <= w_dl_spoke;
        end
        if (i_cmd.pick) begin
            r_rd_idx <= w_pick_idx;
        end
        if (i_cmd.retire) begin
            r_hold <= r_rd_idx;
        end
        if (i_cmd.emit) begin
            r_out_task <= TASK_ID_W'(r_hold);
            r_out_last <= i_cmd.emit_last;
        end
    end

    // deadline store
    always_ff @(posedge i_clk) begin
        if (i_cmd.dly_write) begin
            r_dl_mem[r_task_idx] <= r_deadline;
        end
        if (i_cmd.pick) begin
            r_rd_data <= r_dl_mem[w_pick_idx];
        end
    end

    assign o_sts.task_ok  = (32'(i_task_id) < 32'(MAX_TASKS));
    assign o_sts.mod_done = w_mod_done;
    assign o_sts.pend_any = |r_pend;
    assign o_sts.hit      = (r_rd_data == r_tick);
    assign o_sts.have     = r_have;
    assign o_sts.out_free = w_out_free;

    assign o_out_valid     = r_out_valid;
    assign o_released_task = r_out_task;
    assign o_last_release  = r_out_last;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result loaded over an untaken beat");
    a_release_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.retire |-> (r_rd_data == r_tick))
        else $error("task released before its deadline");
    a_pend_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend & ~r_waiting) == '0)
        else $error("candidate that is not waiting");
    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_have)
        else $error("emit with no held task");
`endif

endmodule

// File: sv/hws_ctrl.sv
module hws_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hws_pkg::CMD_W-1:0]  i_cmd_code,
    output logic                       o_ready,
    output hws_pkg::t_dp_cmd           o_cmd,
    input  hws_pkg::t_dp_sts           i_sts
);
    import hws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DLY_MOD,
        S_TK_SCAN,
        S_TK_PICK,
        S_TK_CMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;
    logic   w_accept;

    assign w_accept = i_valid && r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    case (t_cmd'(i_cmd_code))
                        CMD_TICK: begin
                            o_cmd.tick_adv = 1'b1;
                            n_state        = S_TK_SCAN;
                        end
                        CMD_DELAY: begin
                            if (i_sts.task_ok) begin
                                n_state = S_DLY_MOD;
                            end
                        end
                        CMD_REMOVE: begin
                            o_cmd.remove = i_sts.task_ok;
                        end
                        default: ;
                    endcase
                end
            end
            S_DLY_MOD: begin
                if (i_sts.mod_done) begin
                    o_cmd.dly_write = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.mod_step = 1'b1;
                end
            end
            S_TK_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_TK_PICK;
            end
            S_TK_PICK: begin
                if (i_sts.pend_any) begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_TK_CMP;
                end else if (!i_sts.have) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_TK_CMP: begin
                if (!i_sts.hit) begin
                    n_state = S_TK_PICK;
                end else if (!i_sts.have) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_TK_PICK;
                end else if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.retire = 1'b1;
                    n_state      = S_TK_PICK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready == (r_state == S_IDLE))
        else $error("ready out of step with controller state");
    a_tick_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.tick_adv |=> (r_state == S_TK_SCAN))
        else $error("tick not followed by spoke scan");
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("walk continued after last release");
`endif

endmodule

// File: tb/sv/hashed_timing_wheel_scheduler_unit_tb.sv
import hws_pkg::*;

// Expected release of one task on the output stream
typedef struct packed {
    logic [4:0] task_idx;
    logic       last;
} t_release;

// Tracks wheel contents and holds the releases still owed by the block
class wheel_scoreboard;
    logic [31:0] now_tick;
    logic [31:0] due_at[32];
    bit          parked[32];
    t_release    owed_q[$];
    int          mismatches;

    function new();
        now_tick   = '0;
        mismatches = 0;
        foreach (parked[i]) begin
            parked[i] = 1'b0;
            due_at[i] = '0;
        end
    endfunction

    // Accepted command: update wheel contents, queue the releases of a tick
    function void note_command(logic [1:0] code, logic [4:0] tid, logic [31:0] dly);
        int hit_cnt;
        hit_cnt = 0;
        case (code)
            CMD_TICK: begin
                now_tick = now_tick + 32'd1;
                // a due task always sits in the current spoke; release by index
                for (int t = 0; t < 32; t++) begin
                    if (parked[t] && due_at[t] == now_tick) begin
                        parked[t] = 1'b0;
                        owed_q.push_back('{task_idx: t[4:0], last: 1'b0});
                        hit_cnt++;
                    end
                end
                if (hit_cnt > 0) begin
                    owed_q[owed_q.size()-1].last = 1'b1;
                end
            end
            CMD_DELAY: begin
                due_at[tid] = now_tick + dly;
                parked[tid] = 1'b1;
            end
            CMD_REMOVE: begin
                parked[tid] = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function void check_release(logic [4:0] got_task, logic got_last);
        t_release want;
        if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("release of task %0d (last %0b) with none owed", got_task, got_last);
            end
            return;
        end
        want = owed_q.pop_front();
        if (got_task !== want.task_idx || got_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("release mismatch: expected task %0d last %0b, got task %0d last %0b",
                         want.task_idx, want.last, got_task, got_last);
            end
        end
    endfunction

    function int owed();
        return owed_q.size();
    endfunction
endclass

module hashed_timing_wheel_scheduler_unit_tb;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;     // no-op code, block must ignore it
    localparam int         RANDOM_ITEMS = 445;     // counted items in the random part
    localparam int         DRAIN_CYCLES = 120;     // idle wait for stray beats at the end
    localparam int         CYCLE_LIMIT  = 2000000;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata  = '0;      // [4:0] task_id, [36:5] delay_ticks, rest zero
    logic [1:0]  s_tuser  = '0;      // [1:0] cmd
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;     // [4:0] released_task, rest zero
    logic        o_m_axis_tlast;

    wheel_scoreboard sb = new();
    int  counted   = 0;     // items that do real work on the wheel
    bit  calm      = 1'b0;  // when set, neither side idles
    int  hold_left = 0;     // receiver stall cycles still to run
    int  cycle_cnt = 0;

    always #4 i_clk = ~i_clk;

    hashed_timing_wheel_scheduler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Delays weighted toward short ones so that most tasks fall due in the run
    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 12);
        end
        if (r < 75) begin
            return $urandom_range(13, 40);
        end
        if (r < 85) begin
            return 32'd0;
        end
        if (r < 92) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // One command beat; returns once the block has taken it
    task automatic send_cmd(input logic [1:0] code, input logic [4:0] tid,
                            input logic [31:0] dly);
        int gap;
        gap = pick_gap();
        if (!(code == CMD_UNUSED || (code == CMD_REMOVE && !sb.parked[tid]))) begin
            counted++;
        end
        // lower valid only when a gap follows, so it never toggles within one step
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= code;
        s_tdata  <= {3'b000, dly, tid};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_command(code, tid, dly);
    endtask

    task automatic tick();
        send_cmd(CMD_TICK, 5'($urandom), $urandom);
    endtask

    // Hold off the sender until every owed release has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed() != 0) @(posedge i_clk);
    endtask

    // Receiver: check each beat taken, then pick the next ready level
    always @(posedge i_clk) begin
        int len;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            sb.check_release(o_m_axis_tdata[4:0], o_m_axis_tlast);
        end
        if (hold_left > 0 && !calm) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            len = pick_gap();
            hold_left <= (len > 0) ? len - 1 : 0;
            m_tready  <= (len == 0);
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int          k;
        int          r;
        int          burst_no;
        logic [31:0] d;
        logic [4:0]  tid;

        burst_no = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tick, unused code, remove of an idle task
        tick();
        send_cmd(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 5'd9, 32'd0);
        // zero delay only comes due after a full counter wrap; all-ones delay likewise
        send_cmd(CMD_DELAY, 5'd0, 32'd0);
        send_cmd(CMD_DELAY, 5'd31, 32'hFFFF_FFFF);
        // several tasks in one spoke, one of them due a full turn later
        send_cmd(CMD_DELAY, 5'd25, 32'd2);
        send_cmd(CMD_DELAY, 5'd7, 32'd2);
        send_cmd(CMD_DELAY, 5'd12, 32'd2);
        send_cmd(CMD_DELAY, 5'd20, 32'd2);
        send_cmd(CMD_DELAY, 5'd3, 32'd10);
        // re-delay of a waiting task moves it to another spoke
        send_cmd(CMD_DELAY, 5'd12, 32'd3);
        send_cmd(CMD_REMOVE, 5'd20, 32'd0);
        send_cmd(CMD_UNUSED, 5'd0, 32'd0);
        // releases: 7 then 25 (last); then 12 alone; then 3 after a full turn
        repeat (10) tick();
        drain();

        // Random: bursts of delays followed by enough ticks, ticks, and noise
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 14) == 0) begin
                calm = !calm;
            end
            if ($urandom_range(0, 59) == 0) begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                // first burst sends every task index once, most with a delay of 3
                if (burst_no == 0) begin
                    k = 32;
                end else if ($urandom_range(0, 3) == 0) begin
                    k = $urandom_range(8, 32);
                end else begin
                    k = $urandom_range(1, 6);
                end
                d = (burst_no == 0) ? 32'd3 : 32'($urandom_range(1, 10));
                for (int i = 0; i < k; i++) begin
                    tid = (burst_no == 0) ? i[4:0] : 5'($urandom);
                    r   = $urandom_range(0, 9);
                    if (r < 6) begin
                        send_cmd(CMD_DELAY, tid, d);
                    end else if (r < 8) begin
                        // same spoke, a turn or two later
                        send_cmd(CMD_DELAY, tid, d + 32'(8 * $urandom_range(1, 2)));
                    end else if (r < 9) begin
                        send_cmd(CMD_DELAY, tid, pick_delay());
                    end else begin
                        send_cmd(CMD_REMOVE, tid, $urandom);
                    end
                end
                burst_no++;
                repeat (int'(d) + $urandom_range(0, 3)) tick();
            end else if (r < 75) begin
                repeat ($urandom_range(1, 4)) tick();
            end else if (r < 92) begin
                send_cmd(CMD_DELAY, 5'($urandom), pick_delay());
            end else if (r < 97) begin
                send_cmd(CMD_REMOVE, 5'($urandom), $urandom);
            end else begin
                send_cmd(CMD_UNUSED, 5'($urandom), $urandom);
            end
        end

        // End: let everything owed arrive, then watch for strays
        calm = 1'b1;
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
